### src/rrts_pkg.sv
// Shared operation codes, status codes and types of the round-robin thread scheduler.
package rrts_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_START    = 2'd0;
    localparam t_op OP_YIELD    = 2'd1;
    localparam t_op OP_FREE     = 2'd2;
    localparam t_op OP_DISPATCH = 2'd3;

    localparam t_status ST_DONE  = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_SAME  = 2'd3;

    localparam int SLOT_OUT_W  = 4;
    localparam int ENTRY_W     = 32;

endpackage

### src/rrts_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler with its link and entry memories.
// A transaction is accepted when start is high and busy is low.
// Its result appears on the result ports in state S_OUT, marked by o_valid.
// A transaction steps through S_EXEC, which uses the head link read, then S_ENT, which finishes
// the tail link write and reads the running entry, and then the result state S_OUT.
// Synchronous active-low reset frees every slot and empties the run queue; the memories
// are not cleared. The receiver cannot stall.
module round_robin_thread_scheduler #(
    parameter int THREAD_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  rrts_pkg::t_op                    i_op,
    input  logic [rrts_pkg::ENTRY_W-1:0]     i_entry_address,
    output logic                             o_valid,
    output rrts_pkg::t_status                o_status,
    output logic [rrts_pkg::SLOT_OUT_W-1:0]  o_assigned_slot,
    output logic                             o_current_valid,
    output logic [rrts_pkg::SLOT_OUT_W-1:0]  o_current_slot,
    output logic [rrts_pkg::ENTRY_W-1:0]     o_current_entry
);

    localparam int SW = $clog2(THREAD_SLOTS + 1);
    localparam int IW = $clog2(THREAD_SLOTS);
    localparam logic [SW-1:0] NONE = SW'(THREAD_SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_ENT  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [THREAD_SLOTS-1:0]     r_ready, n_ready;
    logic [SW-1:0]               r_head, n_head;
    logic [SW-1:0]               r_tail, n_tail;
    logic [SW-1:0]               r_run, n_run;
    rrts_pkg::t_op               r_op;
    logic [rrts_pkg::ENTRY_W-1:0] r_addr;
    logic [SW-1:0]               r_free;
    logic                        r_full;
    rrts_pkg::t_status           r_status, n_status;
    logic [SW-1:0]               r_assigned, n_assigned;
    logic                        r_pend, n_pend;
    logic [SW-1:0]               r_pend_addr, n_pend_addr;
    logic [SW-1:0]               r_pend_data, n_pend_data;

    logic [SW-1:0]               w_free;
    logic                        w_full;
    logic                        w_accept;
    logic                        w_head_ok;
    logic                        w_tail_ok;
    logic                        w_run_ok;
    logic                        w_link_ok;
    logic [SW-1:0]               w_link;

    logic                        link_we;
    logic [IW-1:0]               link_waddr;
    logic [SW-1:0]               link_wdata;
    logic                        ent_we;
    logic [rrts_pkg::ENTRY_W-1:0] ent_rdata;

    assign w_accept  = start && !busy;
    assign w_head_ok = r_head < NONE;
    assign w_tail_ok = r_tail < NONE;
    assign w_run_ok  = r_run < NONE;
    assign w_link_ok = w_link < NONE;

    always_comb begin
        w_free = NONE;
        w_full = 1'b1;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
            if (!r_ready[i]) begin
                w_free = SW'(i);
                w_full = 1'b0;
            end
        end
    end

    rrts_ram #(
        .WIDTH(SW),
        .DEPTH(THREAD_SLOTS)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(r_head[IW-1:0]),
        .o_rdata(w_link)
    );

    rrts_ram #(
        .WIDTH(rrts_pkg::ENTRY_W),
        .DEPTH(THREAD_SLOTS)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (ent_we),
        .i_waddr(r_free[IW-1:0]),
        .i_wdata(r_addr),
        .i_raddr(r_run[IW-1:0]),
        .o_rdata(ent_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_ready     = r_ready;
        n_head      = r_head;
        n_tail      = r_tail;
        n_run       = r_run;
        n_status    = r_status;
        n_assigned  = r_assigned;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_pend_data = r_pend_data;
        link_we     = 1'b0;
        link_waddr  = r_pend_addr[IW-1:0];
        link_wdata  = r_pend_data;
        ent_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state    = S_ENT;
                n_assigned = '0;
                n_pend     = 1'b0;
                unique case (r_op)
                    rrts_pkg::OP_START: begin
                        if (r_full) begin
                            n_status = rrts_pkg::ST_FULL;
                        end else begin
                            n_status    = rrts_pkg::ST_DONE;
                            n_assigned  = r_free;
                            ent_we      = 1'b1;
                            link_we     = 1'b1;
                            link_waddr  = r_free[IW-1:0];
                            link_wdata  = NONE;
                            n_ready[r_free[IW-1:0]] = 1'b1;
                            n_tail      = r_free;
                            if (w_tail_ok) begin
                                n_pend      = 1'b1;
                                n_pend_addr = r_tail;
                                n_pend_data = r_free;
                            end else begin
                                n_head = r_free;
                            end
                        end
                    end
                    rrts_pkg::OP_YIELD: begin
                        if (!w_head_ok) begin
                            n_run    = NONE;
                            n_status = rrts_pkg::ST_EMPTY;
                        end else if (!w_link_ok) begin
                            n_run    = r_head;
                            n_status = rrts_pkg::ST_SAME;
                        end else begin
                            n_status    = rrts_pkg::ST_DONE;
                            n_head      = w_link;
                            n_tail      = r_head;
                            n_run       = w_link;
                            link_we     = 1'b1;
                            link_waddr  = r_head[IW-1:0];
                            link_wdata  = NONE;
                            n_pend      = w_tail_ok;
                            n_pend_addr = r_tail;
                            n_pend_data = r_head;
                        end
                    end
                    rrts_pkg::OP_FREE: begin
                        if (!w_head_ok) begin
                            n_run    = NONE;
                            n_status = rrts_pkg::ST_EMPTY;
                        end else begin
                            n_ready[r_head[IW-1:0]] = 1'b0;
                            if (w_link_ok) begin
                                n_head   = w_link;
                                n_run    = w_link;
                                n_status = rrts_pkg::ST_DONE;
                            end else begin
                                n_head   = NONE;
                                n_tail   = NONE;
                                n_run    = NONE;
                                n_status = rrts_pkg::ST_EMPTY;
                            end
                        end
                    end
                    rrts_pkg::OP_DISPATCH: begin
                        if (!w_head_ok) begin
                            n_run    = NONE;
                            n_status = rrts_pkg::ST_EMPTY;
                        end else if (r_run == r_head) begin
                            n_status = rrts_pkg::ST_SAME;
                        end else begin
                            n_run    = r_head;
                            n_status = rrts_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        n_status = rrts_pkg::ST_SAME;
                    end
                endcase
            end
            S_ENT: begin
                n_state = S_OUT;
                link_we = r_pend;
                n_pend  = 1'b0;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= '0;
            r_head  <= NONE;
            r_tail  <= NONE;
            r_run   <= NONE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_run   <= n_run;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_op;
            r_addr <= i_entry_address;
            r_free <= w_free;
            r_full <= w_full;
        end
        r_status    <= n_status;
        r_assigned  <= n_assigned;
        r_pend_addr <= n_pend_addr;
        r_pend_data <= n_pend_data;
    end

    assign busy            = r_state != S_IDLE;
    assign o_valid         = r_state == S_OUT;
    assign o_status        = r_status;
    assign o_assigned_slot = rrts_pkg::SLOT_OUT_W'(r_assigned);
    assign o_current_valid = w_run_ok;
    assign o_current_slot  = w_run_ok ? rrts_pkg::SLOT_OUT_W'(r_run) : '0;
    assign o_current_entry = w_run_ok ? ent_rdata : '0;

endmodule

### src/rrts_checker.sv
// Port-level assertions of the round-robin thread scheduler and their bind statement.
module rrts_checker #(
    parameter int THREAD_SLOTS = 16
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input rrts_pkg::t_op                    i_op,
    input logic [rrts_pkg::ENTRY_W-1:0]     i_entry_address,
    input logic                             o_valid,
    input rrts_pkg::t_status                o_status,
    input logic [rrts_pkg::SLOT_OUT_W-1:0]  o_assigned_slot,
    input logic                             o_current_valid,
    input logic [rrts_pkg::SLOT_OUT_W-1:0]  o_current_slot,
    input logic [rrts_pkg::ENTRY_W-1:0]     o_current_entry
);

    logic w_unused;
    assign w_unused = ^{i_op, i_entry_address, THREAD_SLOTS};

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result did not appear three cycles after acceptance");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while not busy");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_current_valid) |-> (o_current_slot == '0 && o_current_entry == '0))
        else $error("current slot fields not zero while nothing runs");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == rrts_pkg::ST_FULL) |-> (o_assigned_slot == '0))
        else $error("assigned slot not zero on a full report");

endmodule

bind round_robin_thread_scheduler rrts_checker #(.THREAD_SLOTS(THREAD_SLOTS)) u_rrts_checker (.*);
